### rtl/core/trt_pkg.sv
// Shared types for the Turtle RDF tokenizer: token codes, the token record and
// the two-token bundle that one input item can produce. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package trt_pkg;

    // Token kinds as they appear on the output
    typedef enum logic [2:0] {
        TK_DOT   = 3'd0,
        TK_SEMI  = 3'd1,
        TK_COMMA = 3'd2,
        TK_IRI   = 3'd3,
        TK_LIT   = 3'd4,
        TK_UNK   = 3'd5,
        TK_EOF   = 3'd6
    } t_tok_type;

    localparam int POS_W = 31;

    typedef struct packed {
        t_tok_type          ttype;
        logic [POS_W-1:0]   toff;
        logic [POS_W-1:0]   tlen;
        logic               tlast;
    } t_token;

    // Up to two tokens per input item; v1 is only set together with v0
    typedef struct packed {
        logic   v0;
        logic   v1;
        t_token tok0;
        t_token tok1;
    } t_tok_pair;

endpackage

`default_nettype wire

### rtl/core/trt_scan.sv
// Lexer core: scan state registers and the per-byte next-state/token logic.
// Depends on trt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trt_scan (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_eod,
    output trt_pkg::t_tok_pair     o_toks
);
    import trt_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE, M_Q1, M_Q2, M_SBODY, M_SESC, M_TBODY, M_SUFFIX,
        M_LT1, M_IRI, M_NAME, M_NINT, M_NFRAC, M_NEXP0, M_NEXPD
    } t_mode;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LC_E   = 8'h65;
    localparam logic [7:0] CH_UC_E   = 8'h45;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_name_tail(input logic [7:0] c);
        return is_letter(c) || is_digit(c) || (c == CH_UNDER) || (c == CH_MINUS)
            || (c == CH_COLON);
    endfunction

    t_mode            r_mode,   n_mode;
    logic [POS_W-1:0] r_pos,    n_pos;
    logic [POS_W-1:0] r_start,  n_start;
    logic             r_single, n_single;
    logic [1:0]       r_run,    n_run;
    logic [7:0]       r_prev,   n_prev;

    logic [7:0]       q_char;
    logic [POS_W-1:0] len_here, len_incl;
    logic [1:0]       run_inc;
    logic             is_sfx_end;

    // token opened by the byte that starts something new
    t_mode            bg_mode;
    logic             bg_start, bg_quote, bg_emit;
    t_tok_type        bg_type;

    logic             do_begin;
    logic             a_v, b_v;
    t_token           a_tok, b_tok;
    t_tok_type        pend_type;

    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_start  = r_start;
        n_single = r_single;
        n_run    = r_run;
        n_prev   = r_prev;

        q_char     = r_single ? CH_SQUOTE : CH_DQUOTE;
        len_here   = r_pos - r_start;
        len_incl   = r_pos + {{(POS_W-1){1'b0}}, 1'b1} - r_start;
        run_inc    = ((r_run == 2'd0) && (r_prev == CH_BSLASH)) ? r_run : r_run + 2'd1;
        is_sfx_end = is_blank(i_byte) || (i_byte == CH_DOT) || (i_byte == CH_SEMI)
                  || (i_byte == CH_COMMA);

        // decode of a byte seen between tokens
        bg_mode  = M_IDLE;
        bg_start = 1'b0;
        bg_quote = 1'b0;
        bg_emit  = 1'b0;
        bg_type  = TK_UNK;
        if (is_blank(i_byte)) begin
            bg_mode = M_IDLE;
        end else if ((i_byte == CH_DQUOTE) || (i_byte == CH_SQUOTE)) begin
            bg_mode  = M_Q1;
            bg_start = 1'b1;
            bg_quote = 1'b1;
        end else if (i_byte == CH_LT) begin
            bg_mode  = M_LT1;
            bg_start = 1'b1;
        end else if (i_byte == CH_GT) begin
            bg_emit = 1'b1;
        end else if (is_letter(i_byte) || (i_byte == CH_COLON) || (i_byte == CH_UNDER)) begin
            bg_mode  = M_NAME;
            bg_start = 1'b1;
        end else if (is_digit(i_byte)) begin
            bg_mode  = M_NINT;
            bg_start = 1'b1;
        end else if (i_byte == CH_DOT) begin
            bg_emit = 1'b1;
            bg_type = TK_DOT;
        end else if (i_byte == CH_SEMI) begin
            bg_emit = 1'b1;
            bg_type = TK_SEMI;
        end else if (i_byte == CH_COMMA) begin
            bg_emit = 1'b1;
            bg_type = TK_COMMA;
        end else begin
            bg_emit = 1'b1;
        end

        case (r_mode)
            M_LT1, M_IRI, M_NAME:              pend_type = TK_IRI;
            M_NINT, M_NFRAC, M_NEXP0, M_NEXPD: pend_type = TK_UNK;
            default:                           pend_type = TK_LIT;
        endcase

        do_begin = 1'b0;
        a_v      = 1'b0;
        b_v      = 1'b0;
        a_tok    = '{ttype: TK_IRI, toff: r_start, tlen: len_here, tlast: 1'b0};
        b_tok    = '{ttype: bg_type, toff: r_pos, tlen: {{(POS_W-1){1'b0}}, 1'b1},
                     tlast: 1'b0};

        if (i_eod) begin
            // flush whatever is open, then EOF at the current position
            a_v         = (r_mode != M_IDLE);
            a_tok.ttype = pend_type;
            b_v         = 1'b1;
            b_tok       = '{ttype: TK_EOF, toff: r_pos, tlen: '0, tlast: 1'b0};
            n_mode      = M_IDLE;
            n_run       = 2'd0;
        end else begin
            case (r_mode)
                M_Q1: begin
                    if (i_byte == q_char)         n_mode = M_Q2;
                    else if (i_byte == CH_BSLASH) n_mode = M_SESC;
                    else                          n_mode = M_SBODY;
                end
                M_Q2: begin
                    if (i_byte == q_char) begin
                        n_mode = M_TBODY;
                        n_run  = 2'd0;
                    end else if (is_sfx_end) begin
                        a_v         = 1'b1;
                        a_tok.ttype = TK_LIT;
                        do_begin    = 1'b1;
                    end else begin
                        n_mode = M_SUFFIX;
                    end
                end
                M_SBODY: begin
                    if (i_byte == q_char)         n_mode = M_SUFFIX;
                    else if (i_byte == CH_BSLASH) n_mode = M_SESC;
                end
                M_SESC: begin
                    n_mode = M_SBODY;
                end
                M_TBODY: begin
                    if (i_byte == q_char) begin
                        if (run_inc == 2'd3) begin
                            n_run  = 2'd0;
                            n_mode = M_SUFFIX;
                        end else begin
                            n_run = run_inc;
                        end
                    end else begin
                        n_run = 2'd0;
                    end
                end
                M_SUFFIX: begin
                    if (is_sfx_end) begin
                        a_v         = 1'b1;
                        a_tok.ttype = TK_LIT;
                        do_begin    = 1'b1;
                    end
                end
                M_LT1: begin
                    if (i_byte == CH_LT) begin
                        // double angle: first '<' stands alone
                        a_v        = 1'b1;
                        a_tok      = '{ttype: TK_UNK, toff: r_start,
                                       tlen: {{(POS_W-1){1'b0}}, 1'b1}, tlast: 1'b0};
                        do_begin   = 1'b1;
                    end else if (i_byte == CH_GT) begin
                        a_v        = 1'b1;
                        a_tok.tlen = len_incl;
                        n_mode     = M_IDLE;
                    end else begin
                        n_mode = M_IRI;
                    end
                end
                M_IRI: begin
                    if (i_byte == CH_GT) begin
                        a_v        = 1'b1;
                        a_tok.tlen = len_incl;
                        n_mode     = M_IDLE;
                    end
                end
                M_NAME: begin
                    if (!is_name_tail(i_byte)) begin
                        a_v      = 1'b1;
                        do_begin = 1'b1;
                    end
                end
                M_NINT: begin
                    if (is_digit(i_byte)) begin
                        n_mode = M_NINT;
                    end else if (i_byte == CH_DOT) begin
                        n_mode = M_NFRAC;
                    end else if ((i_byte == CH_LC_E) || (i_byte == CH_UC_E)) begin
                        n_mode = M_NEXP0;
                    end else begin
                        a_v         = 1'b1;
                        a_tok.ttype = TK_UNK;
                        do_begin    = 1'b1;
                    end
                end
                M_NFRAC: begin
                    if (is_digit(i_byte)) begin
                        n_mode = M_NFRAC;
                    end else if ((i_byte == CH_LC_E) || (i_byte == CH_UC_E)) begin
                        n_mode = M_NEXP0;
                    end else begin
                        a_v         = 1'b1;
                        a_tok.ttype = TK_UNK;
                        do_begin    = 1'b1;
                    end
                end
                M_NEXP0: begin
                    if ((i_byte == CH_PLUS) || (i_byte == CH_MINUS) || is_digit(i_byte)) begin
                        n_mode = M_NEXPD;
                    end else begin
                        a_v         = 1'b1;
                        a_tok.ttype = TK_UNK;
                        do_begin    = 1'b1;
                    end
                end
                M_NEXPD: begin
                    if (!is_digit(i_byte)) begin
                        a_v         = 1'b1;
                        a_tok.ttype = TK_UNK;
                        do_begin    = 1'b1;
                    end
                end
                default: begin
                    do_begin = 1'b1;
                end
            endcase

            if (do_begin) begin
                n_mode = bg_mode;
                b_v    = bg_emit;
                if (bg_start) n_start = r_pos;
                if (bg_quote) begin
                    n_single = (i_byte == CH_SQUOTE);
                    n_run    = 2'd0;
                end
            end
            n_prev = i_byte;
            n_pos  = r_pos + {{(POS_W-1){1'b0}}, 1'b1};
        end

        // pack into slot order, mark the last one
        o_toks.v0   = a_v || b_v;
        o_toks.v1   = a_v && b_v;
        o_toks.tok0 = a_v ? a_tok : b_tok;
        o_toks.tok1 = b_tok;
        o_toks.tok0.tlast = !(a_v && b_v);
        o_toks.tok1.tlast = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_pos    <= '0;
            r_start  <= '0;
            r_single <= 1'b0;
            r_run    <= 2'd0;
            r_prev   <= 8'd0;
        end else if (i_step) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_start  <= n_start;
            r_single <= n_single;
            r_run    <= n_run;
            r_prev   <= n_prev;
        end
    end

endmodule

`default_nettype wire

### rtl/core/trt_outq.sv
// Four-entry token queue: per cycle up to two tokens in and, if ready, one out.
// Depends on trt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trt_outq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  trt_pkg::t_tok_pair     i_toks,
    output logic                   o_room2,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output trt_pkg::t_token        o_tok
);
    import trt_pkg::*;

    t_token     r_mem [4];
    logic [1:0] r_wr, n_wr;
    logic [1:0] r_rd, n_rd;
    logic [2:0] r_cnt, n_cnt;
    logic       wr0, wr1, pop;

    assign wr0     = i_push && i_toks.v0;
    assign wr1     = i_push && i_toks.v1;
    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != 3'd0);
    assign o_room2 = (r_cnt <= 3'd2);
    assign o_tok   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr + {1'b0, wr0} + {1'b0, wr1};
        n_rd  = r_rd + {1'b0, pop};
        n_cnt = r_cnt + {2'b00, wr0} + {2'b00, wr1} - {2'b00, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr0) r_mem[r_wr] <= i_toks.tok0;
        if (wr1) r_mem[r_wr + 2'd1] <= i_toks.tok1;
    end

endmodule

`default_nettype wire

### rtl/core/turtle_rdf_tokenizer.sv
// Top level of the Turtle RDF tokenizer: input register, lexer core, token queue.
// Depends on trt_pkg, trt_scan and trt_outq.
//
// Usage:
//   Input channel s_axis: one text byte per item in tdata; tuser = 1 marks end of
//   data (tdata ignored), which flushes any open token and then gives an EOF token.
//   Output channel m_axis: one token per item; tdata = type, offset, length;
//   tlast marks the last token caused by one input item. An input item causes
//   zero, one or two tokens.
//   Path: a taken item sits in the input register and is lexed from there; its
//   tokens are written into the queue and reach m_axis behind any queued ones.
//   Throughput: one input item per cycle while the queue has room for two
//   tokens. The lexer state update is combinational logic into its registers,
//   so the rate is bounded only by the output side, where tokens leave one at
//   a time; an item causing two tokens is buffered by the four-token queue.
//   Stall: while m_axis_tready is low the queue fills; once fewer than two free
//   slots remain the held item waits in the input register, and s_axis_tready
//   drops when that register is occupied too. Nothing is lost or reordered.
//   Reset (i_rst_n low, synchronous): lexer idle, position and token start zero,
//   queue empty, input register empty.
`timescale 1ns / 1ps
`default_nettype none

module turtle_rdf_tokenizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input byte stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] end_of_data
    // token stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // [2:0] token_type, [33:3] token_offset,
                                             // [64:34] token_length, [71:65] zero
    output logic             m_axis_tlast    // last_of_run
);
    import trt_pkg::*;

    // input register
    logic       r_iv;
    logic [7:0] r_ibyte;
    logic       r_ieod;

    logic       step;
    logic       room2;
    t_tok_pair  toks;
    t_token     out_tok;

    // lex the held item only when the queue can take two tokens
    assign step          = r_iv && room2;
    assign s_axis_tready = !r_iv || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (s_axis_tready) begin
            r_iv <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_ibyte <= s_axis_tdata;
            r_ieod  <= s_axis_tuser;
        end
    end

    trt_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_ibyte),
        .i_eod   (r_ieod),
        .o_toks  (toks)
    );

    trt_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_toks  (toks),
        .o_room2 (room2),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_tok   (out_tok)
    );

    assign m_axis_tdata = {7'd0, out_tok.tlen, out_tok.toff, out_tok.ttype};
    assign m_axis_tlast = out_tok.tlast;

endmodule

`default_nettype wire

### rtl/core/trt_checker.sv
// Port-level checks for the Turtle RDF tokenizer, bound to the top level.
// Depends on trt_pkg and turtle_rdf_tokenizer.
`timescale 1ns / 1ps
`default_nettype none

module trt_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [71:0] m_axis_tdata,
    input  wire logic        m_axis_tlast
);
    import trt_pkg::*;

    logic       s_fire;
    logic [2:0] tok_type;
    logic [30:0] tok_len;

    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign tok_type = m_axis_tdata[2:0];
    assign tok_len  = m_axis_tdata[64:34];

    // EOF always closes the run of its item and carries no bytes
    a_eof_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (tok_type == TK_EOF)) |-> (m_axis_tlast && (tok_len == 31'd0)))
        else $error("EOF token with nonzero length or without tlast");

    // punctuation tokens are exactly one byte
    a_punct_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && ((tok_type == TK_DOT) || (tok_type == TK_SEMI)
                           || (tok_type == TK_COMMA))) |-> (tok_len == 31'd1))
        else $error("punctuation token length is not one");

    // once the output runs empty it cannot restart without an accepted input item
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(m_axis_tvalid) && !$past(s_fire)) |=> (!m_axis_tvalid || $past(s_fire)))
        else $error("token appeared without an accepted input item");

    // a stalled token holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("output token changed while stalled");

endmodule

bind turtle_rdf_tokenizer trt_checker u_trt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

### tb/sv/turtle_rdf_tokenizer_test.sv
// Self-checking testbench for turtle_rdf_tokenizer: byte stream in, tokens out.
// A built-in lexer predicts every token; depends on trt_pkg and the tokenizer RTL.
`timescale 1ns / 1ps

module turtle_rdf_tokenizer_test;
    import trt_pkg::*;

    localparam int QUIET_LIMIT = 1000;    // cycles with no handshake at all
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_BYTES = 1800;

    localparam logic [7:0] CH_BSL    = 8'h5C;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_DQ     = 8'h22;
    localparam logic [7:0] CH_SQ     = 8'h27;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_UP_E   = 8'h45;

    // lexer modes of the predictor
    typedef enum logic [4:0] {
        MD_IDLE, MD_Q1, MD_Q2, MD_SBODY, MD_SESC, MD_TBODY, MD_SUFFIX,
        MD_LT1, MD_IRI, MD_NAME, MD_NINT, MD_NFRAC, MD_NEXP0, MD_NEXPD
    } scan_state_e;

    typedef struct packed {
        logic [7:0] data;
        logic       eod;
    } text_item_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tuser = 1'b0;    // [0] end_of_data
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;           // [2:0] type, [33:3] offset, [64:34] length
    logic        m_axis_tlast;

    text_item_t bytes_pending[$];
    t_token     tokens_due[$];
    t_token     fresh[2];                // tokens of the byte being lexed
    int         fresh_n;

    // predictor state
    scan_state_e      lx_mode = MD_IDLE;
    logic [POS_W-1:0] lx_pos = '0;
    logic [POS_W-1:0] lx_start = '0;
    logic             lx_single = 1'b0;
    logic [1:0]       lx_qrun = '0;
    logic [7:0]       lx_prev = '0;

    logic in_taken = 1'b0;
    int   items_taken = 0;
    int   errors = 0;
    int   quiet = 0;
    int   src_gap = 0;
    int   sink_wait = 0;
    int   hold_left = 0;
    int   next_hold_at = 400;
    bit   src_calm = 1'b0;
    bit   sink_calm = 1'b0;

    turtle_rdf_tokenizer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic bit is_blank(input logic [7:0] c);
        return c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_name_tail(input logic [7:0] c);
        return is_letter(c) || is_digit(c) || c == CH_USCORE || c == CH_MINUS || c == CH_COLON;
    endfunction

    task automatic push_tok(input t_tok_type kind, input logic [POS_W-1:0] off,
                            input logic [POS_W-1:0] len);
        if (fresh_n < 2) begin
            fresh[fresh_n] = '{ttype: kind, toff: off, tlen: len, tlast: 1'b0};
            fresh_n++;
        end
    endtask

    // byte c at position p opens the next token, is a token by itself, or is a blank
    task automatic start_tok(input logic [7:0] c, input logic [POS_W-1:0] p);
        lx_mode = MD_IDLE;
        if (is_blank(c))
            return;
        if (c == CH_DQ || c == CH_SQ) begin
            lx_mode = MD_Q1;
            lx_start = p;
            lx_single = (c == CH_SQ);
            lx_qrun = '0;
        end else if (c == CH_LT) begin
            lx_mode = MD_LT1;
            lx_start = p;
        end else if (c == CH_GT) begin
            push_tok(TK_UNK, p, POS_W'(1));
        end else if (is_letter(c) || c == CH_COLON || c == CH_USCORE) begin
            lx_mode = MD_NAME;
            lx_start = p;
        end else if (is_digit(c)) begin
            lx_mode = MD_NINT;
            lx_start = p;
        end else if (c == CH_DOT) begin
            push_tok(TK_DOT, p, POS_W'(1));
        end else if (c == CH_SEMI) begin
            push_tok(TK_SEMI, p, POS_W'(1));
        end else if (c == CH_COMMA) begin
            push_tok(TK_COMMA, p, POS_W'(1));
        end else begin
            push_tok(TK_UNK, p, POS_W'(1));
        end
    endtask

    task automatic close_tok(input t_tok_type kind, input logic [7:0] c,
                             input logic [POS_W-1:0] p);
        push_tok(kind, lx_start, p - lx_start);
        start_tok(c, p);
    endtask

    // literal suffix runs up to whitespace or punctuation
    task automatic suffix_byte(input logic [7:0] c, input logic [POS_W-1:0] p);
        if (is_blank(c) || c == CH_DOT || c == CH_SEMI || c == CH_COMMA)
            close_tok(TK_LIT, c, p);
        else
            lx_mode = MD_SUFFIX;
    endtask

    // Advance the lexer by one item and queue the tokens it produces.
    task automatic lex_byte(input logic [7:0] c, input logic eod);
        logic [7:0] q;
        t_tok_type  kind;
        t_token     tok;
        fresh_n = 0;
        q = lx_single ? CH_SQ : CH_DQ;
        if (eod) begin
            if (lx_mode != MD_IDLE) begin
                case (lx_mode)
                    MD_LT1, MD_IRI, MD_NAME:               kind = TK_IRI;
                    MD_NINT, MD_NFRAC, MD_NEXP0, MD_NEXPD: kind = TK_UNK;
                    default:                               kind = TK_LIT;
                endcase
                push_tok(kind, lx_start, lx_pos - lx_start);
            end
            lx_mode = MD_IDLE;
            lx_qrun = '0;
            push_tok(TK_EOF, lx_pos, '0);
        end else begin
            case (lx_mode)
                MD_Q1: begin
                    if (c == q)           lx_mode = MD_Q2;
                    else if (c == CH_BSL) lx_mode = MD_SESC;
                    else                  lx_mode = MD_SBODY;
                end
                MD_Q2: begin
                    // third quote opens a long literal; else "" closes or gets a suffix
                    if (c == q) begin
                        lx_mode = MD_TBODY;
                        lx_qrun = '0;
                    end else begin
                        suffix_byte(c, lx_pos);
                    end
                end
                MD_SBODY: begin
                    if (c == q)           lx_mode = MD_SUFFIX;
                    else if (c == CH_BSL) lx_mode = MD_SESC;
                end
                MD_SESC: lx_mode = MD_SBODY;
                MD_TBODY: begin
                    // an escaped first quote does not count toward the closing run
                    if (c == q) begin
                        if (!(lx_qrun == 2'd0 && lx_prev == CH_BSL))
                            lx_qrun = lx_qrun + 2'd1;
                        if (lx_qrun == 2'd3) begin
                            lx_qrun = '0;
                            lx_mode = MD_SUFFIX;
                        end
                    end else begin
                        lx_qrun = '0;
                    end
                end
                MD_SUFFIX: suffix_byte(c, lx_pos);
                MD_LT1: begin
                    if (c == CH_LT) begin
                        push_tok(TK_UNK, lx_start, POS_W'(1));
                        start_tok(c, lx_pos);
                    end else if (c == CH_GT) begin
                        push_tok(TK_IRI, lx_start, lx_pos + POS_W'(1) - lx_start);
                        lx_mode = MD_IDLE;
                    end else begin
                        lx_mode = MD_IRI;
                    end
                end
                MD_IRI: begin
                    if (c == CH_GT) begin
                        push_tok(TK_IRI, lx_start, lx_pos + POS_W'(1) - lx_start);
                        lx_mode = MD_IDLE;
                    end
                end
                MD_NAME: if (!is_name_tail(c)) close_tok(TK_IRI, c, lx_pos);
                MD_NINT: begin
                    // a dot right after the digits always stays in the number
                    if (c == CH_DOT)                        lx_mode = MD_NFRAC;
                    else if (c == CH_LOW_E || c == CH_UP_E) lx_mode = MD_NEXP0;
                    else if (!is_digit(c))                  close_tok(TK_UNK, c, lx_pos);
                end
                MD_NFRAC: begin
                    if (c == CH_LOW_E || c == CH_UP_E) lx_mode = MD_NEXP0;
                    else if (!is_digit(c))             close_tok(TK_UNK, c, lx_pos);
                end
                MD_NEXP0: begin
                    if (c == CH_PLUS || c == CH_MINUS || is_digit(c)) lx_mode = MD_NEXPD;
                    else close_tok(TK_UNK, c, lx_pos);
                end
                MD_NEXPD: if (!is_digit(c)) close_tok(TK_UNK, c, lx_pos);
                default: start_tok(c, lx_pos);
            endcase
            lx_prev = c;
            lx_pos = lx_pos + POS_W'(1);
        end
        for (int i = 0; i < fresh_n; i++) begin
            tok = fresh[i];
            tok.tlast = (i == fresh_n - 1);
            tokens_due.push_back(tok);
        end
    endtask

    // ---------------------------------------------------------------- stimulus

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // gap length: mostly none or short, now and then long; none in calm stretches
    function automatic int idle_len(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_byte(input logic [7:0] b);
        bytes_pending.push_back('{data: b, eod: 1'b0});
    endtask

    task automatic add_eod();
        // data byte is don't-care here, so send noise
        bytes_pending.push_back('{data: 8'($urandom_range(0, 255)), eod: 1'b1});
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic add_suffix();
        case ($urandom_range(0, 9))
            6, 7:    add_text("@en");
            8:       add_text("^^xsd:int");
            9:       add_text("^^<t>");
            default: ;
        endcase
    endtask

    // one mostly well-formed Turtle fragment followed by an optional separator
    task automatic add_fragment();
        int         kind;
        int         r;
        logic [7:0] qc;
        kind = $urandom_range(0, 99);
        qc = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
        if (kind < 12) begin
            add_byte(CH_LT);
            repeat ($urandom_range(0, 8)) add_byte(pick("abz09/:#.-<"));
            if ($urandom_range(0, 9) != 0)
                add_byte(CH_GT);
        end else if (kind < 27) begin
            add_byte(pick("abxyzAZ:_"));
            repeat ($urandom_range(0, 7)) add_byte(pick("abqzAZ09_-:"));
        end else if (kind < 37) begin
            repeat ($urandom_range(1, 4)) add_byte(pick("0123456789"));
            if ($urandom_range(0, 1)) begin
                add_byte(CH_DOT);
                repeat ($urandom_range(0, 3)) add_byte(pick("0123456789"));
            end
            if ($urandom_range(0, 2) == 0) begin
                add_byte(pick("eE"));
                if ($urandom_range(0, 1))
                    add_byte(pick("+-"));
                repeat ($urandom_range(0, 3)) add_byte(pick("0123456789"));
            end
        end else if (kind < 52) begin
            add_byte(qc);
            repeat ($urandom_range(0, 6)) begin
                if ($urandom_range(0, 5) == 0) begin
                    add_byte(CH_BSL);
                    add_byte($urandom_range(0, 2) == 0 ? qc : pick("abn\\t"));
                end else begin
                    add_byte(pick("abc XY9.;,<>\"'"));
                end
            end
            add_byte(qc);
            add_suffix();
        end else if (kind < 62) begin
            repeat (3) add_byte(qc);
            repeat ($urandom_range(0, 8)) begin
                r = $urandom_range(0, 7);
                if (r == 0)      add_byte(CH_BSL);
                else if (r == 1) add_byte(qc);
                else             add_byte(pick("ab \n.;\"'"));
            end
            repeat ($urandom_range(3, 4)) add_byte(qc);
            add_suffix();
        end else if (kind < 82) begin
            add_byte(pick(".;,"));
        end else if (kind < 87) begin
            add_text($urandom_range(0, 1) ? "<<" : ">");
        end else if (kind < 98) begin
            repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
        end else begin
            add_eod();
        end
        r = $urandom_range(0, 9);
        if (r < 6)      add_byte(pick(" \t\r\n"));
        else if (r < 8) add_byte(pick(".;,"));
    endtask

    initial begin : stimulus
        int directed_n;
        // byte extremes, double angle then lone '>', empty string, long literal
        // closed after an escaped quote and followed by a suffix, dot, semicolon, then
        // unterminated name, repeated end of data and unterminated literal
        add_byte(8'h00);
        add_byte(8'hFF);
        add_text("<<a>>\"\" '''x\\''''1.;a");
        add_eod();
        add_eod();
        add_text("\"z");
        add_eod();
        directed_n = bytes_pending.size();
        while (bytes_pending.size() < directed_n + RANDOM_BYTES)
            add_fragment();
        add_eod();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_pending.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        while (tokens_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- driver

    // A pending item stays on the bus until taken; new items go out on the falling edge.
    always @(negedge i_clk) begin : drive_bytes
        text_item_t nxt;
        if (i_rst_n && !(s_axis_tvalid && !in_taken)) begin
            if ($urandom_range(0, 199) == 0)
                src_calm = !src_calm;
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (bytes_pending.size() != 0) begin
                nxt = bytes_pending.pop_front();
                s_axis_tdata  <= nxt.data;
                s_axis_tuser  <= nxt.eod;
                s_axis_tvalid <= 1'b1;
                src_gap = idle_len(src_calm);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Token receiver: random stalls, plus a long hold-off now and then so the
    // output queue fills and the input side backs up.
    always @(negedge i_clk) begin : drive_ready
        if (i_rst_n) begin
            if ($urandom_range(0, 199) == 0)
                sink_calm = !sink_calm;
            if (items_taken >= next_hold_at) begin
                hold_left = 80;
                next_hold_at += 900;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (sink_wait > 0) begin
                sink_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                sink_wait = idle_len(sink_calm);
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    task automatic flag(input string what, input logic [71:0] want, input logic [71:0] got);
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin : watch_ports
        t_token want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            // check first: a token never belongs to the item taken at this same edge
            if (m_axis_tvalid && m_axis_tready) begin
                if (tokens_due.size() == 0) begin
                    flag("unexpected token", '0, m_axis_tdata);
                end else begin
                    want = tokens_due.pop_front();
                    if (m_axis_tdata[2:0] !== want.ttype)
                        flag("token_type", want.ttype, m_axis_tdata[2:0]);
                    if (m_axis_tdata[33:3] !== want.toff)
                        flag("token_offset", want.toff, m_axis_tdata[33:3]);
                    if (m_axis_tdata[64:34] !== want.tlen)
                        flag("token_length", want.tlen, m_axis_tdata[64:34]);
                    if (m_axis_tdata[71:65] !== 7'd0)
                        flag("tdata padding", '0, m_axis_tdata[71:65]);
                    if (m_axis_tlast !== want.tlast)
                        flag("last_of_run", want.tlast, m_axis_tlast);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                lex_byte(s_axis_tdata, s_axis_tuser);
                items_taken <= items_taken + 1;
            end
        end
    end

    // watchdog: ends a run that has stopped moving on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d tokens outstanding",
                         $time, quiet, tokens_due.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule
